@@ hdl/retry_backoff_delay_defines.svh @@
// Assertion macros used by the retry backoff delay checker.
`ifndef RETRY_BACKOFF_DELAY_DEFINES_SVH
`define RETRY_BACKOFF_DELAY_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("retry backoff delay: assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define RBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("retry backoff delay: assertion failed");

`endif

@@ hdl/rbd_pkg.sv @@
// Shared constants, codes and types of the retry backoff delay block.
package rbd_pkg;

  localparam int MAX_SHIFT_DEF  = 10;
  localparam int LAST_WIDTH_DEF = 48;

  localparam int DELAY_W = 32;
  localparam int WORD_W  = 32;
  localparam int RETRY_W = 16;

  // Algorithm codes
  localparam logic [2:0] ALG_DEFAULT  = 3'd0;
  localparam logic [2:0] ALG_DECORR   = 3'd1;
  localparam logic [2:0] ALG_FULL     = 3'd2;
  localparam logic [2:0] ALG_EQUAL    = 3'd3;
  localparam logic [2:0] ALG_EXP      = 3'd4;
  localparam logic [2:0] ALG_UNIFORM  = 3'd5;
  localparam logic [2:0] ALG_CONSTANT = 3'd6;

  // Register indexes
  localparam logic [1:0] REG_ALG  = 2'd0;
  localparam logic [1:0] REG_BASE = 2'd1;
  localparam logic [1:0] REG_CAP  = 2'd2;

  // Request to the serial modulo unit
  typedef struct packed {
    logic [WORD_W-1:0] word;     // dividend
    logic [WORD_W:0]   modulus;  // 1 .. 2^32
    logic              bypass;   // modulus exceeds word range: remainder is the word
  } mod_req_t;

endpackage

@@ hdl/rbd_modulo.sv @@
// Serial restoring modulo unit: one dividend bit per cycle.
module rbd_modulo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  rbd_pkg::mod_req_t          req,
  output logic                       done,
  output logic [rbd_pkg::WORD_W-1:0] rem
);
  import rbd_pkg::*;

  logic              run;
  logic [4:0]        cnt;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W:0]   modulus;
  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] rem_next;

  // shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, dvd[WORD_W-1]};
    if (trial >= modulus) begin
      rem_next = WORD_W'(trial - modulus);
    end else begin
      rem_next = trial[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (req.bypass) begin
          done <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      modulus <= req.modulus;
      dvd     <= req.word;
      rem     <= req.bypass ? req.word : '0;
    end else if (run) begin
      rem <= rem_next;
      dvd <= {dvd[WORD_W-2:0], 1'b0};
    end
  end

endmodule

@@ hdl/retry_backoff_delay.sv @@
// Retry backoff delay: one compute beat (tuser 0) gives one delay beat; a clear beat
// (tuser 1) zeroes the remembered decorrelated-jitter delay and gives nothing. Items are
// handled one at a time and s_tready is high only while the block is idle. A clear beat
// leaves the block idle. A compute beat that needs no random draw (exponential, constant,
// default with a non-zero retry index) goes through prep and finish to the result
// register. A drawn delay sets up in prep, runs in the serial modulo unit while div waits
// for it to finish, adds the lower bound in sum and is loaded in finish; when the range
// is wider than the random word the word is the remainder as it stands and the modulo
// unit skips its serial steps. The block is ready again the cycle after the result is
// loaded. The result sits in an output register, so the next item may be accepted while
// it waits for m_tready; a new result is loaded only once the previous one is going, and
// a stalled result holds the block in its last state. The user is to write registers
// through cfg_we/cfg_index/cfg_wdata only while idle, which the block does not enforce:
// 0 algorithm, 1 base delay, 2 cap. Exponential forms use base << min(retry, MAX_SHIFT)
// at full width before capping; the decorrelated delay saturates at LAST_WIDTH bits.
module retry_backoff_delay #(
  parameter int MAX_SHIFT  = rbd_pkg::MAX_SHIFT_DEF,
  parameter int LAST_WIDTH = rbd_pkg::LAST_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_wdata,
  // input beats
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [47:0]                 s_tdata,   // [15:0] retry_number, [47:16] random_word
  input  logic                        s_tuser,   // [0] mode
  // result beats
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rbd_pkg::DELAY_W-1:0] m_tdata    // [31:0] delay_value
);
  import rbd_pkg::*;

  localparam int HW   = LAST_WIDTH + 2;           // width of 3 * last_delay
  localparam int EXPW = DELAY_W + MAX_SHIFT;      // shifted base at full precision
  localparam int SHW  = (MAX_SHIFT > 0) ? $clog2(MAX_SHIFT + 1) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SUM,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [2:0]         alg_sel;
  logic [DELAY_W-1:0] base_delay;
  logic [DELAY_W-1:0] delay_cap;

  // remembered decorrelated delay
  logic [LAST_WIDTH-1:0] last_delay;

  // item in flight
  logic [RETRY_W-1:0] retry_number;
  logic [WORD_W-1:0]  random_word;
  logic [HW-1:0]      lo;
  logic [DELAY_W-1:0] t_val;
  logic [HW:0]        draw;

  // PREP logic
  logic [SHW-1:0]     sh;
  logic [EXPW-1:0]    exp_val;
  logic [DELAY_W-1:0] t_calc;
  logic [HW-1:0]      three_last;
  logic [HW-1:0]      lo_a, hi_a, lo_s, hi_s;
  logic [HW:0]        modulus;
  logic               need_draw;
  mod_req_t           mreq;
  logic               div_start;
  logic               div_done;
  logic [WORD_W-1:0]  div_rem;

  // FINISH logic
  logic [LAST_WIDTH-1:0] new_last;
  logic [DELAY_W-1:0]    d;
  logic                  out_free;

  always_comb begin
    sh = (retry_number > RETRY_W'(MAX_SHIFT)) ? SHW'(MAX_SHIFT) : SHW'(retry_number);
    exp_val = EXPW'(base_delay) << sh;
    t_calc = (exp_val > EXPW'(delay_cap)) ? delay_cap : exp_val[DELAY_W-1:0];
    three_last = (HW'(last_delay) << 1) + HW'(last_delay);

    case (alg_sel)
      ALG_DECORR: begin
        lo_a = HW'(base_delay);
        hi_a = three_last;
      end
      ALG_FULL, ALG_EQUAL: begin
        lo_a = '0;
        hi_a = HW'(t_calc);
      end
      default: begin
        lo_a = '0;
        hi_a = HW'(base_delay);
      end
    endcase

    // reversed bounds are swapped
    if (hi_a < lo_a) begin
      lo_s = hi_a;
      hi_s = lo_a;
    end else begin
      lo_s = lo_a;
      hi_s = hi_a;
    end
    modulus = {1'b0, hi_s} - {1'b0, lo_s} + (HW+1)'(1);

    case (alg_sel)
      ALG_DEFAULT:                                   need_draw = (retry_number == '0);
      ALG_DECORR, ALG_FULL, ALG_EQUAL, ALG_UNIFORM:  need_draw = 1'b1;
      default:                                       need_draw = 1'b0;
    endcase

    mreq.word    = random_word;
    mreq.modulus = modulus[WORD_W:0];
    mreq.bypass  = (modulus > (HW+1)'(33'h1_0000_0000));
  end

  assign div_start = (state == ST_PREP) && need_draw;

  rbd_modulo u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (mreq),
    .done  (div_done),
    .rem   (div_rem)
  );

  // result selection
  always_comb begin
    new_last = (draw > (HW+1)'({LAST_WIDTH{1'b1}})) ? {LAST_WIDTH{1'b1}}
                                                   : draw[LAST_WIDTH-1:0];
    case (alg_sel)
      ALG_DEFAULT: begin
        if (retry_number != '0) begin
          d = (base_delay > delay_cap) ? delay_cap : base_delay;
        end else begin
          d = (draw[DELAY_W-1:0] > delay_cap) ? delay_cap : draw[DELAY_W-1:0];
        end
      end
      ALG_DECORR:  d = (new_last > LAST_WIDTH'(delay_cap)) ? delay_cap
                                                           : new_last[DELAY_W-1:0];
      ALG_FULL:    d = draw[DELAY_W-1:0];
      ALG_EQUAL:   d = {1'b0, t_val[DELAY_W-1:1]} + {1'b0, draw[DELAY_W-1:1]};
      ALG_EXP:     d = t_val;
      ALG_UNIFORM: d = (draw[DELAY_W-1:0] > delay_cap) ? delay_cap : draw[DELAY_W-1:0];
      default:     d = (base_delay > delay_cap) ? delay_cap : base_delay;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      alg_sel    <= ALG_DEFAULT;
      base_delay <= '0;
      delay_cap  <= '0;
      last_delay <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALG:  alg_sel    <= cfg_wdata[2:0];
          REG_BASE: base_delay <= cfg_wdata;
          REG_CAP:  delay_cap  <= cfg_wdata;
          default: ;
        endcase
      end

      // a new result takes the place of one going out in the same cycle
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              last_delay <= '0;
            end else begin
              retry_number <= s_tdata[15:0];
              random_word  <= s_tdata[47:16];
              state        <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          lo    <= lo_s;
          t_val <= t_calc;
          state <= need_draw ? ST_DIV : ST_FINISH;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          draw  <= (HW+1)'(lo) + (HW+1)'(div_rem);
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // wait for the output register to empty
          if (out_free) begin
            m_tdata  <= d;
            if (alg_sel == ALG_DECORR) begin
              last_delay <= new_last;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/rbd_checker.sv @@
// Port-level checks of the retry backoff delay block, bound to the top level.
`include "retry_backoff_delay_defines.svh"

module rbd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [rbd_pkg::DELAY_W-1:0] m_tdata
);

  // a compute beat makes the block busy
  `RBD_ASSERT_NEXT(a_busy_after_compute, s_tvalid && s_tready && !s_tuser, !s_tready)

  // a clear beat gives no result and leaves the block ready
  `RBD_ASSERT_NEXT(a_clear_stays_ready, s_tvalid && s_tready && s_tuser, s_tready)

  // a new result only appears at the end of a busy spell
  `RBD_ASSERT_NOW(a_result_after_busy, $rose(m_tvalid), $past(!s_tready))

  // stalled result beat holds
  `RBD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind retry_backoff_delay rbd_checker u_rbd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ verif/retry_backoff_delay_tb.sv @@
// Self-checking testbench for the retry backoff delay block: directed and random beats.
module retry_backoff_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000; // watchdog, several times the slowest run
  localparam int          RANDOM_ITEMS = 1800;
  localparam int          IDLE_PCT     = 27;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          PRINT_CAP    = 50;     // keep the log short on a broken build

  // Delay predictor and store of owed delays, in arrival order.
  class backoff_scoreboard;
    logic [2:0]  alg;
    logic [63:0] base;
    logic [63:0] cap;
    logic [63:0] prev_delay;   // remembered decorrelated delay, LAST_WIDTH bits
    logic [31:0] owed_delays[$];
    int          mismatches;

    function new();
      alg        = ALG_DEFAULT;
      base       = '0;
      cap        = '0;
      prev_delay = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_ALG:  alg  = value[2:0];
        REG_BASE: base = {32'd0, value};
        REG_CAP:  cap  = {32'd0, value};
        default: ;
      endcase
    endfunction

    function logic [63:0] lesser(logic [63:0] a, logic [63:0] b);
      return (a < b) ? a : b;
    endfunction

    // Draw in [lo,hi], bounds swapped when reversed; spans here stay far below 2^64.
    function logic [63:0] draw_in(logic [63:0] lo, logic [63:0] hi, logic [31:0] word);
      logic [63:0] t;
      if (hi < lo) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      return lo + ({32'd0, word} % (hi - lo + 64'd1));
    endfunction

    // One accepted input beat: update state and queue the delay it owes, if any.
    function void note_beat(bit clear, logic [15:0] retry, logic [31:0] word);
      logic [63:0] scaled;
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] last_max;
      int unsigned sh;
      last_max = (64'd1 << LAST_WIDTH_DEF) - 64'd1;
      if (clear) begin
        prev_delay = '0;
        return;
      end
      sh     = (retry > MAX_SHIFT_DEF) ? MAX_SHIFT_DEF : retry;
      scaled = base << sh;   // full width, cannot wrap
      t      = lesser(cap, scaled);
      case (alg)
        ALG_DEFAULT: d = lesser(cap, (retry != 0) ? base : draw_in(64'd0, base, word));
        ALG_DECORR: begin
          prev_delay = lesser(draw_in(base, prev_delay * 64'd3, word), last_max);
          d = lesser(cap, prev_delay);
        end
        ALG_FULL:    d = draw_in(64'd0, t, word);
        ALG_EQUAL:   d = (t >> 1) + (draw_in(64'd0, t, word) >> 1);
        ALG_EXP:     d = t;
        ALG_UNIFORM: d = lesser(cap, draw_in(64'd0, base, word));
        default:     d = lesser(cap, base);  // constant, and the unused selector
      endcase
      owed_delays.push_back(d[31:0]);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_delay(logic [31:0] got);
      logic [31:0] want;
      if (owed_delays.size() == 0) begin
        flag_mismatch($sformatf("delay beat 0x%08h with nothing owed", got));
      end else begin
        want = owed_delays.pop_front();
        if (got !== want)
          flag_mismatch($sformatf("delay_value 0x%08h, predicted 0x%08h", got, want));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ALG;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;    // [15:0] retry_number, [47:16] random_word
  logic        s_tuser = 1'b0;  // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [DELAY_W-1:0] m_tdata;  // [31:0] delay_value

  backoff_scoreboard sb;
  int          idle_pct = IDLE_PCT;
  int unsigned cycle_count = 0;

  retry_backoff_delay DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake or a lost delay beat ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** retry_backoff_delay: FAILED **");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle so stalls land on any output state.
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= idle_pct);
  end

  // Delay beats are checked as they are taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_delay(m_tdata);
  end

  // Present one input beat; entered and left at a falling edge. Valid is held high
  // across back-to-back beats and lowered only for an idle gap.
  task automatic send_item(bit clear, logic [15:0] retry, logic [31:0] word);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = clear;
    s_tdata  = {word, retry};
    do @(posedge clk); while (!s_tready);
    sb.note_beat(clear, retry, word);
    @(negedge clk);
  endtask

  // Block idle: every owed delay has gone, a trailing clear beat is through and s_tready is high.
  task automatic settle();
    s_tvalid = 1'b0;
    while (sb.owed_delays.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (!s_tready) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(logic [2:0] alg, logic [31:0] base, logic [31:0] cap);
    settle();
    write_reg(REG_ALG, {29'd0, alg});
    write_reg(REG_BASE, base);
    write_reg(REG_CAP, cap);
  endtask

  // Register values lean on the edges: zero, all ones, small and mid-sized intervals.
  function automatic logic [31:0] pick_reg_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return 32'd0;
    if (roll < 22) return 32'hFFFF_FFFF;
    if (roll < 47) return $urandom_range(1, 1000);
    if (roll < 72) return $urandom_range(0, 32'h000F_FFFF);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 32'd0;
    if (roll < 16) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic directed_part();
    // default: draw on the first try, base afterwards
    configure(ALG_DEFAULT, 32'd1000, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd0, 32'hFFFF_FFFF);
    send_item(1'b0, 16'hFFFF, 32'd0);
    // decorrelated, wide base: reversed bounds first, then a span wider than the word
    configure(ALG_DECORR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd0, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd1, 32'hFFFF_FFFF);
    send_item(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd2, 32'd0);
    // decorrelated under a low cap, cleared mid-way
    configure(ALG_DECORR, 32'd100, 32'd50);
    send_item(1'b0, 16'd0, 32'd7);
    send_item(1'b0, 16'd1, 32'd12345);
    send_item(1'b1, 16'd0, 32'd0);
    send_item(1'b0, 16'd2, 32'hFFFF_FFFF);
    // full jitter with the shift clamped and a shifted base beyond 32 bits
    configure(ALG_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd10, 32'hFFFF_FFFF);
    send_item(1'b0, 16'hFFFF, 32'h1234_5678);
    configure(ALG_EQUAL, 32'd7, 32'd1000);
    send_item(1'b0, 16'd0, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd11, 32'd12345);
    configure(ALG_EXP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd10, 32'd0);
    configure(ALG_EXP, 32'd1, 32'hFFFF_FFFF);
    send_item(1'b0, 16'hFFFF, 32'd0);
    configure(ALG_UNIFORM, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(1'b0, 16'd3, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd4, 32'd0);
    configure(ALG_CONSTANT, 32'd5, 32'd3);
    send_item(1'b0, 16'd9, 32'd99);
    // unused selector behaves as constant
    configure(3'd7, 32'd9, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd0, 32'd1);
    // zero cap and base: every form collapses to zero
    configure(ALG_FULL, 32'd0, 32'd0);
    send_item(1'b0, 16'd5, 32'hFFFF_FFFF);
  endtask

  // Random phases: mostly retry loops counting up from zero and sometimes restarting,
  // with stray retry indexes and clear beats mixed in.
  task automatic random_part();
    int          sent;
    int          phase;
    int          roll;
    logic [15:0] attempt;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      configure(3'($urandom_range(0, 7)), pick_reg_value(), pick_reg_value());
      // a run of phases with both sides always ready
      idle_pct = (phase >= 8 && phase < 14) ? 0 : IDLE_PCT;
      attempt  = '0;
      repeat ($urandom_range(15, 60)) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          send_item(1'b1, 16'($urandom), $urandom);
          attempt = '0;
        end else if (roll < 20) begin
          send_item(1'b0, 16'($urandom), pick_word());
        end else begin
          send_item(1'b0, attempt, pick_word());
          attempt = ($urandom_range(0, 99) < 12) ? 16'd0 : attempt + 16'd1;
        end
        sent++;
      end
      phase++;
    end
    idle_pct = IDLE_PCT;
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed_part();
    random_part();
    s_tvalid = 1'b0;
    while (sb.owed_delays.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** retry_backoff_delay: PASSED **");
    end else begin
      $display("** retry_backoff_delay: FAILED **");
    end
    $finish;
  end

endmodule
